[hdl/cerl_pkg.sv]
`timescale 1ns / 1ps

package cerl_pkg;

    // number formats
    localparam int PROB_FRAC_BITS = 15;
    localparam int LOSS_FRAC_BITS = 16;
    localparam int PROB_W         = 16;
    localparam int X_W            = PROB_W + 1;
    localparam int EXP_W          = 5;
    localparam int MANT_W         = 31;
    localparam int INT_W          = 6;
    localparam int LOG2_FRAC      = 28;
    localparam int L2_W           = INT_W + LOG2_FRAC;
    localparam int L2_LO_W        = 17;
    localparam int L2_HI_W        = L2_W - L2_LO_W;
    localparam int LN2_W          = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam int LN_SHIFT       = 26;
    localparam int LN_W           = 40;
    localparam int PROD_W         = PROB_W + 1 + LN_W;
    localparam int TERM_SHIFT     = 32 + PROB_FRAC_BITS - LOSS_FRAC_BITS;
    localparam int TERM_W         = PROD_W - TERM_SHIFT;
    localparam int SUM_W          = 48;
    localparam int LOSS_W         = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ITER_W         = $clog2(LOG2_FRAC);

    // normalized log argument, as classified by the front end
    typedef struct packed {
        logic [EXP_W-1:0]  exp;
        logic [MANT_W-1:0] mant;
        logic [PROB_W-1:0] weight;
        logic              last;
    } cerl_item_t;

    // natural log result handed to the accumulator
    typedef struct packed {
        logic signed [LN_W-1:0] ln;
        logic [PROB_W-1:0]      weight;
        logic                   last;
    } cerl_ln_t;

    typedef enum logic [2:0] {
        LOG_IDLE,
        LOG_ITER,
        LOG_MUL_LO,
        LOG_MUL_HI,
        LOG_SUM,
        LOG_DONE
    } cerl_log_state_t;

    typedef enum logic [1:0] {
        ACC_IDLE,
        ACC_MUL,
        ACC_ADD
    } cerl_acc_state_t;

endpackage

[hdl/cerl_front.sv]
`timescale 1ns / 1ps

module cerl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [cerl_pkg::PROB_W-1:0]   cfg_wdata,
    input  logic [cerl_pkg::PROB_W-1:0]   probability,
    input  logic [cerl_pkg::PROB_W-1:0]   target_weight,
    input  logic                          row_end,
    output cerl_pkg::cerl_item_t          item
);
    import cerl_pkg::*;

    logic [PROB_W-1:0] guard_reg;
    logic [X_W-1:0]    x;
    logic [EXP_W-1:0]  top_bit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg <= PROB_W'(1);
        end else if (cfg_we) begin
            guard_reg <= cfg_wdata;
        end
    end

    always_comb begin
        x = X_W'(probability) + X_W'(guard_reg);
        // log of zero is taken as log of one LSB
        if (x == '0) begin
            x = X_W'(1);
        end
        top_bit = '0;
        for (int i = 0; i < X_W; i++) begin
            if (x[i]) begin
                top_bit = EXP_W'(i);
            end
        end
    end

    assign item.exp    = top_bit;
    assign item.mant   = MANT_W'({{(MANT_W-X_W){1'b0}}, x} << (EXP_W'(MANT_W - 1) - top_bit));
    assign item.weight = target_weight;
    assign item.last   = row_end;

endmodule

[hdl/cerl_queue.sv]
`timescale 1ns / 1ps

module cerl_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  cerl_pkg::cerl_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output cerl_pkg::cerl_item_t pop_item
);
    import cerl_pkg::*;

    cerl_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

[hdl/cerl_log.sv]
`timescale 1ns / 1ps

module cerl_log (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  cerl_pkg::cerl_item_t item,
    output logic                 ln_valid,
    input  logic                 ln_ready,
    output cerl_pkg::cerl_ln_t   ln_out
);
    import cerl_pkg::*;

    cerl_log_state_t          state_reg, state_next;
    logic [ITER_W-1:0]        cnt_reg;
    logic [MANT_W-1:0]        m_reg;
    logic [LOG2_FRAC-1:0]     frac_reg;
    logic signed [INT_W-1:0]  int_reg;
    logic [PROB_W-1:0]        weight_reg;
    logic                     last_reg;
    logic [L2_LO_W+LN2_W-1:0] plo_reg;
    logic signed [L2_HI_W+LN2_W:0] phi_reg;
    logic signed [LN_W-1:0]   ln_reg;

    logic [2*MANT_W-1:0]      sq;
    logic [MANT_W:0]          msq;
    logic signed [L2_W-1:0]   l2;
    logic signed [L2_W+LN2_W+1:0] full_prod;
    logic signed [L2_W+LN2_W+1:0] rounded;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LOG_IDLE:   if (item_valid) state_next = LOG_ITER;
            LOG_ITER:   if (cnt_reg == ITER_W'(LOG2_FRAC - 1)) state_next = LOG_MUL_LO;
            LOG_MUL_LO: state_next = LOG_MUL_HI;
            LOG_MUL_HI: state_next = LOG_SUM;
            LOG_SUM:    state_next = LOG_DONE;
            LOG_DONE:   if (ln_ready) state_next = LOG_IDLE;
            default:    state_next = LOG_IDLE;
        endcase
    end

    always_comb begin
        item_ready = (state_reg == LOG_IDLE);
        ln_valid   = (state_reg == LOG_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LOG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // one squaring per cycle; each step yields one fraction bit of log2
    assign sq  = (2*MANT_W)'(m_reg) * (2*MANT_W)'(m_reg);
    assign msq = sq[2*MANT_W-1:MANT_W-1];
    assign l2  = {int_reg, frac_reg};
    assign full_prod = (L2_W+LN2_W+2)'(phi_reg) * (L2_W+LN2_W+2)'(2**L2_LO_W)
                     + $signed({2'b00, (L2_W+LN2_W)'(plo_reg)});
    assign rounded   = (full_prod + (L2_W+LN2_W+2)'(2**(LN_SHIFT-1))) >>> LN_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (state_reg == LOG_IDLE) begin
            cnt_reg <= '0;
        end else if (state_reg == LOG_ITER) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            LOG_IDLE: begin
                m_reg      <= item.mant;
                int_reg    <= $signed({1'b0, item.exp}) - INT_W'(PROB_FRAC_BITS);
                weight_reg <= item.weight;
                last_reg   <= item.last;
                frac_reg   <= '0;
            end
            LOG_ITER: begin
                if (msq[MANT_W]) begin
                    m_reg    <= msq[MANT_W:1];
                    frac_reg <= {frac_reg[LOG2_FRAC-2:0], 1'b1};
                end else begin
                    m_reg    <= msq[MANT_W-1:0];
                    frac_reg <= {frac_reg[LOG2_FRAC-2:0], 1'b0};
                end
            end
            LOG_MUL_LO: plo_reg <= (L2_LO_W+LN2_W)'(l2[L2_LO_W-1:0]) * (L2_LO_W+LN2_W)'(LN2_Q30);
            LOG_MUL_HI: phi_reg <= (L2_HI_W+LN2_W+1)'($signed(l2[L2_W-1:L2_LO_W]))
                                 * $signed({{(L2_HI_W+1){1'b0}}, LN2_Q30});
            LOG_SUM:    ln_reg  <= rounded[LN_W-1:0];
            LOG_DONE:   ;
            default:    ;
        endcase
    end

    assign ln_out.ln     = ln_reg;
    assign ln_out.weight = weight_reg;
    assign ln_out.last   = last_reg;

    a_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == LOG_ITER) |-> m_reg[MANT_W-1])
        else $error("mantissa lost normalization");

endmodule

[hdl/cerl_accum.sv]
`timescale 1ns / 1ps

module cerl_accum (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ln_valid,
    output logic                                ln_ready,
    input  cerl_pkg::cerl_ln_t                  ln_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cerl_pkg::LOSS_W-1:0]  row_loss,
    output logic                                overflow
);
    import cerl_pkg::*;

    cerl_acc_state_t         state_reg, state_next;
    cerl_ln_t                hold_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    out_valid_reg;
    logic signed [LOSS_W-1:0] loss_reg;
    logic                    ovf_reg;

    logic                    out_free, sum_upd, out_load;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W:0]   sum_ext;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [SUM_W:0]   neg;
    logic signed [LOSS_W-1:0] loss_sat;
    logic                    loss_ovf;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ACC_IDLE: if (ln_valid) state_next = ACC_MUL;
            ACC_MUL:  state_next = ACC_ADD;
            ACC_ADD:  if (!hold_reg.last || out_free) state_next = ACC_IDLE;
            default:  state_next = ACC_IDLE;
        endcase
    end

    always_comb begin
        ln_ready = (state_reg == ACC_IDLE);
        sum_upd  = (state_reg == ACC_ADD) && (!hold_reg.last || out_free);
        out_load = (state_reg == ACC_ADD) && hold_reg.last && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ACC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ACC_IDLE && ln_valid) begin
            hold_reg <= ln_in;
        end
        if (state_reg == ACC_MUL) begin
            prod_reg <= $signed({1'b0, hold_reg.weight}) * hold_reg.ln;
        end
    end

    always_comb begin
        prod_rnd = (prod_reg + PROD_W'(2**(TERM_SHIFT-1))) >>> TERM_SHIFT;
        term     = prod_rnd[TERM_W-1:0];
        sum_ext  = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(term);
        // 48-bit clamp
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
        neg = -(SUM_W+1)'(sum_sat);
        if (neg[SUM_W:LOSS_W-1] != {(SUM_W-LOSS_W+2){neg[SUM_W]}}) begin
            loss_ovf = 1'b1;
            loss_sat = neg[SUM_W] ? {1'b1, {(LOSS_W-1){1'b0}}} : {1'b0, {(LOSS_W-1){1'b1}}};
        end else begin
            loss_ovf = 1'b0;
            loss_sat = neg[LOSS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sum_upd) begin
                sum_reg <= hold_reg.last ? '0 : sum_sat;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            loss_reg <= loss_sat;
            ovf_reg  <= loss_ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_loss  = loss_reg;
    assign overflow  = ovf_reg;

    a_load_from_add: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ACC_ADD && hold_reg.last))
        else $error("result raised outside row end");

endmodule

[hdl/cross_entropy_row_loss_core.sv]
`timescale 1ns / 1ps

// Cross-entropy row loss. Row elements arrive on the s_ stream: s_tdata
// carries probability and target weight (unsigned Q1.15), s_tlast marks the
// last element of a row. For each element the core adds weight * ln(p + guard)
// into a 48-bit saturating sum; on a row end it sends -sum as a signed Q16.16
// loss on m_tdata, m_tuser high when the loss was clamped, and clears the sum.
// The guard offset is written through cfg_we/cfg_wdata; the user must write it
// only while idle; the core itself does not enforce this. Each element passes
// through the log unit as load, 28 squaring steps on one 31x31 multiplier, two
// ln2 partial products, rounding and hand-off; this loop sets the throughput:
// the log unit takes no new element until it hands off the last one. A
// two-entry queue in front of it keeps s_tready high until the queue fills.
// Reset (aresetn low, synchronous) empties the queue, zeroes the sum and sets
// the guard to 1. When the receiver stalls, the result is held in the output
// register; elements keep flowing until the next row end needs that register.
module cross_entropy_row_loss_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] probability, [31:16] target_weight
    input  logic        s_tlast,   // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] row_loss
    output logic        m_tuser    // [0] overflow
);
    import cerl_pkg::*;

    cerl_item_t item_in, item_q;
    logic       q_valid, q_ready;
    cerl_ln_t   ln_bus;
    logic       ln_valid, ln_ready;
    logic signed [LOSS_W-1:0] loss;

    cerl_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .probability   (s_tdata[15:0]),
        .target_weight (s_tdata[31:16]),
        .row_end       (s_tlast),
        .item          (item_in)
    );

    cerl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (item_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (item_q)
    );

    cerl_log u_log (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (item_q),
        .ln_valid   (ln_valid),
        .ln_ready   (ln_ready),
        .ln_out     (ln_bus)
    );

    cerl_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ln_valid  (ln_valid),
        .ln_ready  (ln_ready),
        .ln_in     (ln_bus),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .row_loss  (loss),
        .overflow  (m_tuser)
    );

    assign m_tdata = loss;

endmodule

[verif/row_loss_checker.sv]
`timescale 1ns / 1ps

module row_loss_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] probability, [31:16] target_weight
    input  logic        s_tlast,   // row_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] row_loss
    input  logic        m_tuser,   // [0] overflow
    output int          mismatch_count,
    output int          pending_results
);
    import cerl_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam logic signed [63:0] SUM_HI  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SUM_LO  = -(64'sd1 <<< (SUM_W - 1));
    localparam logic signed [63:0] LOSS_HI = (64'sd1 <<< (LOSS_W - 1)) - 64'sd1;
    localparam logic signed [63:0] LOSS_LO = -(64'sd1 <<< (LOSS_W - 1));

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic              ovf;
    } row_result_t;

    row_result_t        expected_losses[$];
    row_result_t        want;
    logic [PROB_W-1:0]  guard;
    logic signed [63:0] row_sum;
    logic signed [63:0] next_sum;
    logic signed [63:0] loss;
    int                 mismatches = 0;
    int                 rows_seen  = 0;

    // floor((v + 2^(s-1)) / 2^s): halves round up
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                     input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // ln(arg / 2^PROB_FRAC_BITS) in Q.32, log2 by repeated squaring
    function automatic logic signed [63:0] natural_log_q32(input logic [X_W-1:0] arg);
        logic [X_W-1:0]     xv;
        int                 top;
        logic [63:0]        mant;
        logic signed [63:0] frac;
        logic signed [63:0] l2;
        logic signed [63:0] ln2;
        xv   = (arg == '0) ? X_W'(1) : arg;
        top  = 0;
        for (int i = 0; i < X_W; i++)
            if (xv[i]) top = i;
        mant = 64'(xv) << (30 - top);
        frac = '0;
        for (int i = 0; i < LOG2_FRAC; i++) begin
            frac = frac <<< 1;
            mant = (mant * mant) >> 30;
            if (mant >= (64'd1 << 31)) begin
                frac = frac + 64'sd1;
                mant = mant >> 1;
            end
        end
        l2  = top - PROB_FRAC_BITS;
        l2  = (l2 <<< LOG2_FRAC) + frac;
        ln2 = 64'(LN2_Q30);
        return round_shr(l2 * ln2, LN_SHIFT);
    endfunction

    function automatic logic signed [63:0] element_term(input logic [PROB_W-1:0] prob,
                                                        input logic [PROB_W-1:0] weight,
                                                        input logic [PROB_W-1:0] offset);
        logic [X_W-1:0]     arg;
        logic signed [63:0] w;
        arg = {1'b0, prob} + {1'b0, offset};
        w   = 64'(weight);
        return round_shr(w * natural_log_q32(arg), TERM_SHIFT);
    endfunction

    task automatic report_field(input string field, input logic signed [31:0] want_v,
                                input logic signed [31:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("row %0d %s: expected %0d, got %0d", rows_seen, field, want_v, got_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            guard   = 16'd1;
            row_sum = '0;
            expected_losses.delete();
        end else begin
            // outgoing transaction first: a result never comes in its own row-end cycle
            if (m_tvalid && m_tready) begin
                rows_seen++;
                if (expected_losses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("row %0d: unexpected result, loss %0d overflow %b",
                                 rows_seen, $signed(m_tdata), m_tuser);
                end else begin
                    want = expected_losses.pop_front();
                    if (m_tdata !== want.loss)
                        report_field("row_loss", want.loss, m_tdata);
                    if (m_tuser !== want.ovf)
                        report_field("overflow", {31'd0, want.ovf}, {31'd0, m_tuser});
                end
            end
            if (cfg_we)
                guard = cfg_wdata;
            if (s_tvalid && s_tready) begin
                next_sum = row_sum + element_term(s_tdata[15:0], s_tdata[31:16], guard);
                if (next_sum > SUM_HI)
                    next_sum = SUM_HI;
                else if (next_sum < SUM_LO)
                    next_sum = SUM_LO;
                row_sum = next_sum;
                if (s_tlast) begin
                    loss     = -row_sum;
                    want.ovf = 1'b0;
                    if (loss > LOSS_HI) begin
                        loss     = LOSS_HI;
                        want.ovf = 1'b1;
                    end else if (loss < LOSS_LO) begin
                        loss     = LOSS_LO;
                        want.ovf = 1'b1;
                    end
                    want.loss = loss[LOSS_W-1:0];
                    expected_losses.push_back(want);
                    row_sum = '0;
                end
            end
        end
        mismatch_count  <= mismatches;
        pending_results <= expected_losses.size();
    end

endmodule

[verif/cross_entropy_row_loss_core_tb.sv]
`timescale 1ns / 1ps

module cross_entropy_row_loss_core_tb;

    localparam int          SETTLE_CYCLES = 100;
    localparam int          CYCLE_LIMIT   = 400_000;
    localparam int          RANDOM_ITEMS  = 650;
    localparam int          LOW_LOG_LEN   = 160;
    localparam int          HIGH_LOG_LEN  = 160;
    localparam logic [15:0] ONE           = 16'h8000;
    localparam logic [15:0] ALL_ONES      = 16'hFFFF;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int mismatch_count;
    int pending_results;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    cross_entropy_row_loss_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    row_loss_checker loss_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_tready    <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // s_tvalid is only dropped by a gap or a hold, never at the end of a transaction
    task automatic send_element(input logic [15:0] prob, input logic [15:0] weight,
                                input logic row_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {weight, prob};
        s_tlast  <= row_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off the sender until every row loss is out, then let the log unit settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_guard(input logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [15:0] rand_fraction();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)  return 16'd0;
        if (pick < 16) return ONE;
        if (pick < 24) return 16'($urandom);
        if (pick < 40) return 16'($urandom_range(255));
        return 16'($urandom_range(32768));
    endfunction

    function automatic logic [15:0] rand_guard();
        case ($urandom_range(4))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return ONE;
            3:       return 16'($urandom_range(16));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // one-hot targets or a spread target distribution
    task automatic send_random_row(input int len);
        int   hot;
        logic spread;
        hot    = $urandom_range(len - 1);
        spread = ($urandom_range(2) == 0);
        for (int k = 0; k < len; k++)
            send_element(rand_fraction(),
                         spread ? rand_fraction() : ((k == hot) ? ONE : 16'd0),
                         (k == len - 1));
    endtask

    task automatic random_rows(input int item_goal);
        int sent;
        int len;
        sent = 0;
        while (sent < item_goal) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            send_random_row(len);
            sent += len;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 72;

        // guard at its reset value
        send_element(16'd0, ONE, 1'b1);
        send_element(ONE, ONE, 1'b1);
        send_element(16'd16384, 16'd16384, 1'b0);
        send_element(16'd16384, 16'd16384, 1'b1);
        send_element(ALL_ONES, ALL_ONES, 1'b1);
        send_element(16'd12345, 16'd0, 1'b1);
        send_element(16'd8000, 16'd0, 1'b0);
        send_element(16'd20000, ONE, 1'b0);
        send_element(16'd4768, 16'd0, 1'b1);

        // no guard: a zero probability hits the zero log argument
        write_guard(16'd0);
        send_element(16'd0, ONE, 1'b1);
        send_element(16'd0, 16'd0, 1'b1);
        send_element(16'd1, ONE, 1'b1);
        send_element(16'h7FFF, 16'h5555, 1'b0);
        send_element(16'h2AAA, 16'h2AAA, 1'b1);

        write_guard(ONE);
        send_element(ONE, ONE, 1'b1);
        send_element(16'd0, ALL_ONES, 1'b1);

        write_guard(ALL_ONES);
        send_element(ALL_ONES, 16'd1, 1'b1);
        send_element(16'd0, ONE, 1'b1);

        // long row of log(1/32768) terms: large positive loss
        write_guard(16'd1);
        for (int k = 0; k < LOW_LOG_LEN; k++)
            send_element(16'd0, ALL_ONES, (k == LOW_LOG_LEN - 1));

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 17 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                write_guard(rand_guard());
                if (ph == 1 && blk == 1) begin
                    random_rows(RANDOM_ITEMS / 18);
                    drain();
                    random_rows(RANDOM_ITEMS / 18);
                end else begin
                    random_rows(RANDOM_ITEMS / 9);
                end
            end
        end

        // log terms above zero: the loss goes negative
        write_guard(ALL_ONES);
        for (int k = 0; k < HIGH_LOG_LEN; k++)
            send_element(ALL_ONES, ALL_ONES, (k == HIGH_LOG_LEN - 1));

        drain();
        if (mismatch_count == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hdl/cerl_pkg.sv
hdl/cerl_front.sv
hdl/cerl_queue.sv
hdl/cerl_log.sv
hdl/cerl_accum.sv
hdl/cross_entropy_row_loss_core.sv
verif/row_loss_checker.sv
verif/cross_entropy_row_loss_core_tb.sv
